// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Same-cycle implication that also holds through reset.
`define ASSERT_NORST(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ppl_pkg.sv =====
// Types and codes for the positional point list.
// No dependencies; used by the RAM, the top level and the checker.
package ppl_pkg;

  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;

  localparam logic [2:0] ACT_APPEND = 3'd0;
  localparam logic [2:0] ACT_INSERT = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_GET    = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [POS_W-1:0]   position;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } req_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_x;
    logic signed [31:0] read_y;
    logic [COUNT_W-1:0] entry_count;
  } rsp_word_t;

endpackage

// ===== rtl/ppl_ram.sv =====
// Single-port-write, single-port-read point RAM, registered read data.
// Depends on ppl_pkg for the point type.
module ppl_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ppl_pkg::point_t wdata,
  input  logic [AW-1:0]   raddr,
  output ppl_pkg::point_t rdata
);

  ppl_pkg::point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/positional_point_list.sv =====
// Positional point list: one item at a time. Append, clear, unused codes and rejected
// requests go from acceptance straight to S_RESULT; get first reads the RAM in S_GET.
// Insert and remove shift the entries from the position to the tail in S_SHIFT, one
// entry per cycle through the single RAM write port (none for removing the last entry).
// rsp holds one result; a new word is taken while it waits.
// Sync reset clears count and control; point RAM is left as is.
module positional_point_list #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  ppl_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ppl_pkg::rsp_word_t rsp
);

  // count must hold CAPACITY itself; address covers 0..CAPACITY-1
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // common width for comparing the 7-bit position with the count
  localparam int XW = (CW > ppl_pkg::POS_W) ? CW : ppl_pkg::POS_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_GET    = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]         state;
  logic [CW-1:0]      cnt;
  logic [2:0]         op;
  logic [AW-1:0]      pos_r;
  ppl_pkg::point_t    pt;
  logic [CW-1:0]      left;      // reads still to issue in the shift
  logic [AW-1:0]      idx;       // next read address
  logic               pend;      // read data of last cycle waits to be written
  logic [AW-1:0]      pend_addr;
  logic [1:0]         res_status;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;

  // RAM port
  logic            we;
  logic [AW-1:0]   waddr;
  ppl_pkg::point_t wdata;
  logic [AW-1:0]   raddr;
  ppl_pkg::point_t rd_data;

  logic          accept;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic          full;
  logic          pos_le;
  logic          pos_lt;
  logic          is_ins;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  assign pos_x  = XW'(req.position);
  assign cnt_x  = XW'(cnt);
  assign full   = (cnt == CW'(CAPACITY));
  assign pos_le = (pos_x <= cnt_x);
  assign pos_lt = (pos_x <  cnt_x);
  assign is_ins = (op == ppl_pkg::ACT_INSERT);

  ppl_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // RAM access: append writes at accept, get reads at accept, the shift
  // loop reads one entry and writes back the one read in the previous cycle.
  // Insert walks downward, remove upward, so the read and the write in one
  // cycle never hit the same entry.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    if (state == S_IDLE && accept) begin
      if (req.action == ppl_pkg::ACT_APPEND && !full) begin
        we      = 1'b1;
        waddr   = AW'(cnt);
        wdata.x = req.point_x;
        wdata.y = req.point_y;
      end else if (req.action == ppl_pkg::ACT_GET && pos_lt) begin
        raddr = AW'(req.position);
      end
    end else if (state == S_SHIFT) begin
      if (pend) begin
        we    = 1'b1;
        waddr = pend_addr;
        wdata = rd_data;
      end else if (left == '0 && is_ins) begin
        // shift done: drop the new point into the gap
        we    = 1'b1;
        waddr = pos_r;
        wdata = pt;
      end
      if (left != '0) begin
        raddr = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // output slot: filled from S_RESULT, emptied when the word is taken
      if (state == S_RESULT && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_status <= ppl_pkg::ST_DONE;
            res_x      <= '0;
            res_y      <= '0;
            op         <= req.action;
            pos_r      <= AW'(req.position);
            pt.x       <= req.point_x;
            pt.y       <= req.point_y;
            pend       <= 1'b0;
            state      <= S_RESULT;
            case (req.action)
              ppl_pkg::ACT_APPEND: begin
                if (full) begin
                  res_status <= ppl_pkg::ST_FULL;
                end else begin
                  cnt <= cnt + 1'b1;
                end
              end
              ppl_pkg::ACT_INSERT: begin
                if (!pos_le) begin
                  res_status <= ppl_pkg::ST_RANGE;
                end else if (full) begin
                  res_status <= ppl_pkg::ST_FULL;
                end else begin
                  left  <= CW'(cnt_x - pos_x);
                  idx   <= AW'(cnt - 1'b1);
                  state <= S_SHIFT;
                end
              end
              ppl_pkg::ACT_REMOVE: begin
                if (!pos_lt) begin
                  res_status <= ppl_pkg::ST_RANGE;
                end else begin
                  left  <= CW'(cnt_x - pos_x - XW'(1));
                  idx   <= AW'(pos_x + XW'(1));
                  state <= S_SHIFT;
                end
              end
              ppl_pkg::ACT_GET: begin
                if (!pos_lt) begin
                  res_status <= ppl_pkg::ST_RANGE;
                end else begin
                  state <= S_GET;
                end
              end
              ppl_pkg::ACT_CLEAR: begin
                cnt <= '0;
              end
              default: begin
                // unused codes leave the list alone
              end
            endcase
          end
        end
        S_GET: begin
          res_x <= rd_data.x;
          res_y <= rd_data.y;
          state <= S_RESULT;
        end
        S_SHIFT: begin
          pend <= (left != '0);
          if (left != '0) begin
            left <= left - 1'b1;
            if (is_ins) begin
              pend_addr <= AW'(idx + 1'b1);
              idx       <= AW'(idx - 1'b1);
            end else begin
              pend_addr <= AW'(idx - 1'b1);
              idx       <= AW'(idx + 1'b1);
            end
          end else if (!pend) begin
            cnt   <= is_ins ? CW'(cnt + 1'b1) : CW'(cnt - 1'b1);
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          // wait for the output slot, then post the word
          if (!rsp_valid || !rsp_stall) begin
            rsp.status      <= res_status;
            rsp.read_x      <= res_x;
            rsp.read_y      <= res_y;
            rsp.entry_count <= ppl_pkg::COUNT_W'(cnt);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/ppl_checker.sv =====
// Port-level checks for positional_point_list, attached by bind.
// Depends on ppl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ppl_checker #(
  parameter int CAPACITY = 64
) (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input ppl_pkg::rsp_word_t rsp
);

  localparam logic [ppl_pkg::COUNT_W-1:0] CAP_COUNT = ppl_pkg::COUNT_W'(CAPACITY);

  // a held result word stays put
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // reset empties the output slot
  `ASSERT_NORST(a_rsp_reset, clk, $past(rst), !rsp_valid)

  // a full list reports exactly CAPACITY entries
  `ASSERT_IMPLY(a_full_count, clk, rst, rsp_valid && rsp.status == ppl_pkg::ST_FULL, rsp.entry_count == CAP_COUNT)

  // rejected requests read nothing
  `ASSERT_IMPLY(a_reject_zero, clk, rst, rsp_valid && rsp.status != ppl_pkg::ST_DONE, rsp.read_x == '0 && rsp.read_y == '0)

endmodule

bind positional_point_list ppl_checker #(
  .CAPACITY (CAPACITY)
) u_ppl_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
